### rtl/core/cmr_pkg.sv
// ============================================================================
// cmr_pkg: shared types and constants of the curveball matrix randomizer
// Mode codes, register indexes, controller states and the command/status
// structs that join the controller to the datapath.
// ============================================================================
package cmr_pkg;

    // matrix geometry, fixed by the 8-bit row index and 64-bit row bitmap
    localparam int NUM_ROWS = 256;
    localparam int NUM_COLS = 64;

    localparam int ModeWidth = 2;
    localparam int IdxWidth  = 8;
    localparam int CntWidth  = 24;
    localparam int CfgIdxWidth = 1;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_TRADE = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [CfgIdxWidth-1:0] REG_ROWS_IN_USE = 1'd0;
    localparam logic [CfgIdxWidth-1:0] REG_SEED        = 1'd1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_READ_WAIT,
        ST_TRADE_START,
        ST_DRAW_A,
        ST_DRAW_B,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_FETCH_WAIT,
        ST_CHECK,
        ST_POOL,
        ST_SHUF_DRAW,
        ST_SHUF_MUL,
        ST_SHUF_RD,
        ST_SHUF_WR,
        ST_BUILD,
        ST_BUILD_WAIT,
        ST_STORE_A,
        ST_STORE_B,
        ST_TRADE_NEXT,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;     // capture input item
        logic row_write;     // write item row into store
        logic row_read;      // read item row from store
        logic read_out;      // latch read data into row_out
        logic trade_init;    // clamp rows, load trade counter
        logic step_rng;      // advance generator
        logic mul_n;         // product with row count
        logic take_a;        // latch product as row a
        logic take_b;        // latch product as row b
        logic fetch_a;       // read row a
        logic fetch_b;       // read row b
        logic latch_a;       // latch read data as ra
        logic latch_b;       // latch read data as rb
        logic pool_step;     // scan one column into pool
        logic shuf_mul;      // product with m-i
        logic shuf_rd;       // read pool[i], pool[j]
        logic shuf_wr;       // swap and advance i
        logic build_rd;      // read pool[i] for rebuild
        logic build_step;    // merge one column bit
        logic store_a;       // write na
        logic store_b;       // write nb
        logic count_change;  // trade reassigned
        logic trade_dec;     // one trade done
        logic clear_out;     // zero outputs
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic  [ModeWidth-1:0] mode;
        logic  runs_left;     // trades_left nonzero
        logic  rows_equal;    // a == b
        logic  has_unique;    // both rows have unique columns
        logic  pool_done;     // column scan finished
        logic  shuf_done;     // i reached la
        logic  build_done;    // i reached m
    } status_t;

endpackage

### rtl/core/cmr_item_if.sv
// ============================================================================
// cmr_item_if: valid/ready channel interfaces
// Input item, result item and configuration write channels.
// ============================================================================
interface cmr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  row_index;
    logic [63:0] row_in;
    logic [23:0] trade_count;
    modport source (output valid, mode, row_index, row_in, trade_count, input ready);
    modport sink (input valid, mode, row_index, row_in, trade_count, output ready);
endinterface

interface cmr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] row_out;
    logic [23:0] trades_changed;
    modport source (output valid, row_out, trades_changed, input ready);
    modport sink (input valid, row_out, trades_changed, output ready);
endinterface

interface cmr_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/cmr_ctrl.sv
// ============================================================================
// cmr_ctrl: sequencing controller
// Steps each item through write, read or a run of curveball trades; mode 3 goes straight to the result.
// ============================================================================
module cmr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  cmr_pkg::status_t  sts,
    output cmr_pkg::cmd_t     cmd
);

    cmr_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cmr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (sts.mode)
                        cmr_pkg::MODE_WRITE: state_next = cmr_pkg::ST_WRITE;
                        cmr_pkg::MODE_READ:  state_next = cmr_pkg::ST_READ;
                        cmr_pkg::MODE_TRADE: state_next = cmr_pkg::ST_TRADE_START;
                        default:             state_next = cmr_pkg::ST_DONE;
                    endcase
                end
            end
            cmr_pkg::ST_WRITE:       state_next = cmr_pkg::ST_DONE;
            cmr_pkg::ST_READ:        state_next = cmr_pkg::ST_READ_WAIT;
            cmr_pkg::ST_READ_WAIT:   state_next = cmr_pkg::ST_DONE;
            cmr_pkg::ST_TRADE_START: state_next = cmr_pkg::ST_TRADE_NEXT;
            cmr_pkg::ST_TRADE_NEXT:
                state_next = sts.runs_left ? cmr_pkg::ST_DRAW_A : cmr_pkg::ST_DONE;
            cmr_pkg::ST_DRAW_A:      state_next = cmr_pkg::ST_DRAW_B;
            cmr_pkg::ST_DRAW_B:      state_next = cmr_pkg::ST_FETCH_A;
            cmr_pkg::ST_FETCH_A:
                state_next = sts.rows_equal ? cmr_pkg::ST_DRAW_A : cmr_pkg::ST_FETCH_B;
            cmr_pkg::ST_FETCH_B:     state_next = cmr_pkg::ST_FETCH_WAIT;
            cmr_pkg::ST_FETCH_WAIT:  state_next = cmr_pkg::ST_CHECK;
            cmr_pkg::ST_CHECK:
                state_next = sts.has_unique ? cmr_pkg::ST_POOL : cmr_pkg::ST_TRADE_NEXT;
            cmr_pkg::ST_POOL:
                state_next = sts.pool_done ? cmr_pkg::ST_SHUF_DRAW : cmr_pkg::ST_POOL;
            cmr_pkg::ST_SHUF_DRAW:
                state_next = sts.shuf_done ? cmr_pkg::ST_BUILD : cmr_pkg::ST_SHUF_MUL;
            cmr_pkg::ST_SHUF_MUL:    state_next = cmr_pkg::ST_SHUF_RD;
            cmr_pkg::ST_SHUF_RD:     state_next = cmr_pkg::ST_SHUF_WR;
            cmr_pkg::ST_SHUF_WR:     state_next = cmr_pkg::ST_SHUF_DRAW;
            cmr_pkg::ST_BUILD:
                state_next = sts.build_done ? cmr_pkg::ST_STORE_A : cmr_pkg::ST_BUILD_WAIT;
            cmr_pkg::ST_BUILD_WAIT:  state_next = cmr_pkg::ST_BUILD;
            cmr_pkg::ST_STORE_A:     state_next = cmr_pkg::ST_STORE_B;
            cmr_pkg::ST_STORE_B:     state_next = cmr_pkg::ST_TRADE_NEXT;
            cmr_pkg::ST_DONE:        if (out_ready) state_next = cmr_pkg::ST_IDLE;
            default:                 state_next = cmr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            cmr_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
                cmd.clear_out = in_valid;
            end
            cmr_pkg::ST_WRITE:       cmd.row_write = 1'b1;
            cmr_pkg::ST_READ:        cmd.row_read = 1'b1;
            cmr_pkg::ST_READ_WAIT:   cmd.read_out = 1'b1;
            cmr_pkg::ST_TRADE_START: cmd.trade_init = 1'b1;
            cmr_pkg::ST_DRAW_A:
            begin
                cmd.step_rng = 1'b1;
                cmd.mul_n    = 1'b1;
            end
            cmr_pkg::ST_DRAW_B:
            begin
                cmd.take_a   = 1'b1;
                cmd.step_rng = 1'b1;
                cmd.mul_n    = 1'b1;
            end
            cmr_pkg::ST_FETCH_A:
            begin
                cmd.take_b  = 1'b1;
                cmd.fetch_a = 1'b1;
            end
            cmr_pkg::ST_FETCH_B:
            begin
                cmd.fetch_b = 1'b1;
                cmd.latch_a = 1'b1;
            end
            cmr_pkg::ST_FETCH_WAIT:  cmd.latch_b = 1'b1;
            cmr_pkg::ST_CHECK:
            begin
                cmd.trade_dec    = !sts.has_unique;
                cmd.count_change = sts.has_unique;
            end
            cmr_pkg::ST_POOL:        cmd.pool_step = 1'b1;
            cmr_pkg::ST_SHUF_DRAW:   cmd.step_rng = !sts.shuf_done;
            cmr_pkg::ST_SHUF_MUL:    cmd.shuf_mul = 1'b1;
            cmr_pkg::ST_SHUF_RD:     cmd.shuf_rd = 1'b1;
            cmr_pkg::ST_SHUF_WR:     cmd.shuf_wr = 1'b1;
            cmr_pkg::ST_BUILD:       cmd.build_rd = !sts.build_done;
            cmr_pkg::ST_BUILD_WAIT:  cmd.build_step = 1'b1;
            cmr_pkg::ST_STORE_A:     cmd.store_a = 1'b1;
            cmr_pkg::ST_STORE_B:
            begin
                cmd.store_b   = 1'b1;
                cmd.trade_dec = 1'b1;
            end
            cmr_pkg::ST_TRADE_NEXT:  ;
            cmr_pkg::ST_DONE:        out_valid = 1'b1;
            default:                 ;
        endcase
    end

    // a beat is only offered to the input while nothing is in flight
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == cmr_pkg::ST_IDLE))
        else $error("in_ready outside idle");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");
    a_store_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_a |=> cmd.store_b)
        else $error("row a stored without row b");

endmodule

### rtl/core/cmr_dpath.sv
// ============================================================================
// cmr_dpath: row store, generator, pool buffer and trade arithmetic
// Carries out the controller's commands one step at a time.
// ============================================================================
module cmr_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  cmr_pkg::cmd_t     cmd,
    output cmr_pkg::status_t  sts,
    input  logic [1:0]        in_mode,
    input  logic [7:0]        in_row_index,
    input  logic [63:0]       in_row_in,
    input  logic [23:0]       in_trade_count,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output logic [63:0]       row_out,
    output logic [23:0]       trades_changed
);

    localparam int NUM_ROWS = cmr_pkg::NUM_ROWS;
    localparam int NUM_COLS = cmr_pkg::NUM_COLS;
    localparam int RowAw = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int ColAw = $clog2(NUM_COLS);
    localparam int CntW  = ColAw + 1;
    localparam logic [63:0] ColMask = (NUM_COLS >= 64) ? {64{1'b1}} :
        ((64'd1 << NUM_COLS) - 64'd1);

    // storage
    logic [NUM_COLS-1:0] row_mem [NUM_ROWS];
    logic [ColAw-1:0]    pool_mem [NUM_COLS];
    logic [NUM_COLS-1:0] rd_data_reg;
    logic [ColAw-1:0]    pool_i_data_reg, pool_j_data_reg;

    // item and config registers
    logic [1:0]   mode_reg;
    logic [7:0]   idx_reg;
    logic [63:0]  row_in_reg;
    logic [23:0]  count_in_reg;
    logic [8:0]   rows_in_use_reg;
    logic [31:0]  rng_reg;
    logic [23:0]  trades_left_reg;
    logic [23:0]  changed_reg;
    logic [63:0]  row_out_reg;
    logic [8:0]   n_reg;

    // trade registers
    logic [63:0]         prod_reg;
    logic [RowAw-1:0]    a_reg, b_reg;
    logic [NUM_COLS-1:0] ra_reg, rb_reg, ua_reg, ub_reg, na_reg, nb_reg;
    logic [CntW-1:0]     scan_reg, m_reg, la_reg, i_reg;
    logic [ColAw-1:0]    j_reg;

    logic [31:0] rng_next;
    logic [NUM_COLS-1:0] shared;
    logic [8:0] n_clamp;
    logic [CntW-1:0] m_minus_i;
    logic [63:0] shuf_prod;
    logic scan_a, scan_bit;
    logic [ColAw-1:0] scan_col;
    logic [ColAw-1:0] j_calc;

    assign rng_next = rng_reg ^ (rng_reg << 13) ^ ((rng_reg ^ (rng_reg << 13)) >> 17)
        ^ ((rng_reg ^ (rng_reg << 13) ^ ((rng_reg ^ (rng_reg << 13)) >> 17)) << 5);
    assign shared   = ra_reg & rb_reg;
    assign n_clamp  = (rows_in_use_reg > 9'(NUM_ROWS)) ? 9'(NUM_ROWS) : rows_in_use_reg;
    assign m_minus_i = m_reg - i_reg;
    assign shuf_prod = {32'd0, rng_reg} * {{(64-CntW){1'b0}}, m_minus_i};
    assign scan_a   = (scan_reg < CntW'(NUM_COLS));
    assign scan_col = scan_reg[ColAw-1:0];
    assign scan_bit = scan_a ? ua_reg[scan_col] : ub_reg[scan_col];
    // swap partner i + draw, ready while the shuffle product sits in prod_reg
    assign j_calc   = ColAw'(i_reg + prod_reg[32 +: CntW]);

    // row store
    always_ff @(posedge clk)
    begin
        if (cmd.row_write && (32'(idx_reg) < NUM_ROWS))
            row_mem[idx_reg[RowAw-1:0]] <= row_in_reg[NUM_COLS-1:0];
        else if (cmd.store_a)
            row_mem[a_reg] <= na_reg;
        else if (cmd.store_b)
            row_mem[b_reg] <= nb_reg;
        if (cmd.row_read)
            rd_data_reg <= row_mem[idx_reg[RowAw-1:0]];
        else if (cmd.fetch_a)
            rd_data_reg <= row_mem[a_reg];
        else if (cmd.fetch_b)
            rd_data_reg <= row_mem[b_reg];
    end

    // pool buffer
    always_ff @(posedge clk)
    begin
        if (cmd.pool_step && scan_bit)
            pool_mem[m_reg[ColAw-1:0]] <= scan_col;
        else if (cmd.shuf_wr)
        begin
            pool_mem[i_reg[ColAw-1:0]] <= pool_j_data_reg;
            pool_mem[j_reg] <= pool_i_data_reg;
        end
        if (cmd.shuf_rd || cmd.build_rd)
            pool_i_data_reg <= pool_mem[i_reg[ColAw-1:0]];
        if (cmd.shuf_rd)
            pool_j_data_reg <= pool_mem[j_calc];
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= 9'd256;
            rng_reg         <= 32'd1;
            trades_left_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == cmr_pkg::REG_ROWS_IN_USE)
                rows_in_use_reg <= cfg_data[8:0];
            if (cfg_we && cfg_index == cmr_pkg::REG_SEED)
                rng_reg <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
            else if (cmd.step_rng)
                rng_reg <= rng_next;
            if (cmd.trade_init)
                trades_left_reg <= (n_clamp < 9'd2) ? 24'd0 : count_in_reg;
            else if (cmd.trade_dec)
                trades_left_reg <= trades_left_reg - 24'd1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg     <= in_mode;
            idx_reg      <= in_row_index;
            row_in_reg   <= in_row_in & ColMask;
            count_in_reg <= in_trade_count;
        end
        if (cmd.clear_out)
        begin
            row_out_reg <= '0;
            changed_reg <= '0;
        end
        if (cmd.read_out)
            row_out_reg <= (32'(idx_reg) < NUM_ROWS) ? 64'(rd_data_reg) : 64'd0;
        if (cmd.trade_init)
            n_reg <= n_clamp;
        if (cmd.mul_n)
            prod_reg <= 64'(rng_next) * 64'(n_reg);
        if (cmd.take_a)
            a_reg <= prod_reg[32 +: RowAw];
        if (cmd.take_b)
            b_reg <= prod_reg[32 +: RowAw];
        if (cmd.latch_a)
            ra_reg <= rd_data_reg;
        if (cmd.latch_b)
        begin
            rb_reg <= rd_data_reg;
            scan_reg <= '0;
            m_reg    <= '0;
            i_reg    <= '0;
        end
        if (cmd.count_change)
        begin
            changed_reg <= changed_reg + 24'd1;
            ua_reg <= ra_reg & ~shared;
            ub_reg <= rb_reg & ~shared;
            na_reg <= shared;
            nb_reg <= shared;
        end
        if (cmd.pool_step)
        begin
            if (scan_bit)
                m_reg <= m_reg + CntW'(1);
            if (scan_reg == CntW'(NUM_COLS - 1))
                la_reg <= m_reg + CntW'(scan_bit);
            scan_reg <= (scan_reg == CntW'(NUM_COLS - 1)) ? CntW'(NUM_COLS)
                      : (scan_reg == CntW'(2 * NUM_COLS - 1) ? scan_reg : scan_reg + CntW'(1));
        end
        if (cmd.shuf_mul)
            prod_reg <= shuf_prod;
        if (cmd.shuf_rd)
            j_reg <= j_calc;
        if (cmd.shuf_wr)
            i_reg <= i_reg + CntW'(1);
        if (sts.shuf_done && !cmd.pool_step && !cmd.build_step && !cmd.build_rd
            && !cmd.shuf_wr && !cmd.shuf_rd && !cmd.shuf_mul && !cmd.step_rng
            && i_reg == la_reg && scan_reg == CntW'(2 * NUM_COLS - 1))
        begin
            i_reg    <= '0;
            scan_reg <= '0;
        end
        if (cmd.build_step)
        begin
            if (i_reg < la_reg)
                na_reg[pool_i_data_reg] <= 1'b1;
            else
                nb_reg[pool_i_data_reg] <= 1'b1;
            i_reg <= i_reg + CntW'(1);
        end
    end

    // status
    always_comb
    begin
        sts.mode       = mode_reg;
        sts.runs_left  = (trades_left_reg != 24'd0);
        sts.rows_equal = (a_reg == prod_reg[32 +: RowAw]);
        sts.has_unique = ((ra_reg & ~shared) != '0) && ((rb_reg & ~shared) != '0);
        sts.pool_done  = cmd.pool_step && (scan_reg == CntW'(2 * NUM_COLS - 1));
        sts.shuf_done  = (i_reg == la_reg) && (scan_reg == CntW'(2 * NUM_COLS - 1));
        sts.build_done = (i_reg == m_reg) && (scan_reg == '0);
    end

    assign row_out        = row_out_reg;
    assign trades_changed = changed_reg;

    // the shuffle index never passes the pool fill
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shuf_wr |-> (i_reg < m_reg))
        else $error("shuffle index beyond pool");
    a_no_equal_rows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_b |-> (a_reg != b_reg))
        else $error("trade between equal rows");
    a_rng_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rng_reg != 32'd0)
        else $error("generator state zero");

endmodule

### rtl/core/curveball_matrix_randomizer.sv
// ============================================================================
// curveball_matrix_randomizer: curveball trade engine for a 0/1 matrix
// Holds one column bitmap per row and randomizes it by curveball trades.
// ============================================================================
// Usage:
//   in_ch  : items (mode, row_index, row_in, trade_count). Mode 0 writes a
//            row, mode 1 reads it, mode 2 runs trade_count trades.
//   out_ch : one result beat per item (row_out, trades_changed).
//   cfg_ch : register writes, index 0 rows_in_use, index 1 seed. Write only
//            while the block is idle; always ready.
//   One item at a time. A trade run draws two rows, redrawing on an equal
//   pair, fetches both and, per traded pair, scans the columns into the
//   pool one column at a time, shuffles the pool, rebuilds both rows and
//   stores them; the serial column scan sets the pace.
//   Reset clears control, loads rows_in_use 256 and generator state 1;
//   the row store is undefined until written.
//   A stalled result holds in place and no new item is taken until the
//   result beat leaves.
// ============================================================================
module curveball_matrix_randomizer (
    input  logic clk,
    input  logic rst_n,
    cmr_in_if.sink    in_ch,
    cmr_out_if.source out_ch,
    cmr_cfg_if.sink   cfg_ch
);

    cmr_pkg::cmd_t    cmd;
    cmr_pkg::status_t sts;
    cmr_pkg::status_t u_dpath_sts;

    assign cfg_ch.ready = 1'b1;

    cmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cmr_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (u_dpath_sts),
        .in_mode        (in_ch.mode),
        .in_row_index   (in_ch.row_index),
        .in_row_in      (in_ch.row_in),
        .in_trade_count (in_ch.trade_count),
        .cfg_we         (cfg_ch.valid),
        .cfg_index      (cfg_ch.index),
        .cfg_data       (cfg_ch.data),
        .row_out        (out_ch.row_out),
        .trades_changed (out_ch.trades_changed)
    );

    // idle decode sees the live mode
    always_comb
    begin
        sts      = u_dpath_sts;
        sts.mode = in_ch.ready ? in_ch.mode : u_dpath_sts.mode;
    end

endmodule

### dv/tb_curveball_matrix_randomizer.sv
// ============================================================================
// tb_curveball_matrix_randomizer: self-checking bench for the curveball block
// Row write/read items and trade runs go in under random valid and ready
// bursts. A local model of the matrix, generator and trades predicts every
// result beat, and the monitor compares the beats field by field.
// ============================================================================
module tb_curveball_matrix_randomizer;

    localparam int NUM_ROWS   = cmr_pkg::NUM_ROWS;
    localparam int IDLE_LIMIT = 400000;

    typedef struct {
        cmr_pkg::mode_t mode;
        logic [7:0]     row;
        logic [63:0]    bits;
        logic [23:0]    count;
    } row_cmd_t;

    typedef struct {
        logic [63:0] row_out;
        logic [23:0] trades_changed;
    } row_result_t;

    logic clk;
    logic rst_n;

    cmr_in_if  in_ch ();
    cmr_out_if out_ch ();
    cmr_cfg_if cfg_ch ();

    curveball_matrix_randomizer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // pending items and expected result beats
    row_cmd_t    row_cmds[$];
    row_result_t expected_rows[$];

    // local copy of matrix, generator and registers
    logic [63:0] matrix_rows[NUM_ROWS];
    logic [31:0] xorshift_q;
    logic [8:0]  rows_cfg;
    bit          written_rows[NUM_ROWS];

    int errors;
    int in_gap;
    int out_gap;
    int idle_cycles;
    bit quiet;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        errors++;
    endtask

    // xorshift step, then scaled choice among k
    function automatic int unsigned draw_choice(int unsigned k);
        logic [31:0] x;
        logic [63:0] p;
        x = xorshift_q;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        xorshift_q = x;
        p = {32'd0, x} * {32'd0, k};
        return p[63:32];
    endfunction

    // one curveball trade; returns 1 when unique columns were dealt
    function automatic bit curveball_swap(int a, int b);
        logic [63:0] ra, rb, shared, ua, ub, na, nb;
        int pool[64];
        int m, la, j, t;
        ra = matrix_rows[a];
        rb = matrix_rows[b];
        shared = ra & rb;
        ua = ra & ~shared;
        ub = rb & ~shared;
        m = 0;
        if (ua == 0 || ub == 0)
            return 0;
        for (int i = 0; i < 64; i++)
            if (ua[i]) pool[m++] = i;
        la = m;
        for (int i = 0; i < 64; i++)
            if (ub[i]) pool[m++] = i;
        for (int i = 0; i < la; i++)
        begin
            j = (i + draw_choice(m - i)) & 63;
            t = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
        na = shared;
        nb = shared;
        for (int i = 0; i < m; i++)
            if (i < la) na[pool[i]] = 1'b1; else nb[pool[i]] = 1'b1;
        matrix_rows[a] = na;
        matrix_rows[b] = nb;
        return 1;
    endfunction

    function automatic row_result_t apply_matrix_item(row_cmd_t cmd);
        row_result_t res;
        int n, a, b;
        logic [23:0] left;
        res.row_out = '0;
        res.trades_changed = '0;
        case (cmd.mode)
            cmr_pkg::MODE_WRITE: matrix_rows[cmd.row] = cmd.bits;
            cmr_pkg::MODE_READ:  res.row_out = matrix_rows[cmd.row];
            cmr_pkg::MODE_TRADE:
            begin
                n = (rows_cfg > NUM_ROWS) ? NUM_ROWS : rows_cfg;
                left = (n < 2) ? 24'd0 : cmd.count;
                while (left > 0)
                begin
                    a = draw_choice(n);
                    b = draw_choice(n);
                    if (a != b)
                    begin
                        if (curveball_swap(a, b)) res.trades_changed++;
                        left--;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // driver: presents queued items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        row_cmd_t cmd;
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.mode        <= '0;
            in_ch.row_index   <= '0;
            in_ch.row_in      <= '0;
            in_ch.trade_count <= '0;
            in_gap = 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                in_gap = $urandom_range(0, 16);
                in_ch.valid <= 1'b0;
            end
            else if (row_cmds.size() > 0)
            begin
                cmd = row_cmds.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.mode        <= cmd.mode;
                in_ch.row_index   <= cmd.row;
                in_ch.row_in      <= cmd.bits;
                in_ch.trade_count <= cmd.count;
                expected_rows.push_back(apply_matrix_item(cmd));
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor: checks result beats, stalls the output, watches for hangs
    always @(posedge clk or negedge rst_n)
    begin
        row_result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
            idle_cycles = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_rows.size() == 0)
                    report_mismatch("unexpected beat", out_ch.row_out, 64'd0);
                else
                begin
                    want = expected_rows.pop_front();
                    if (out_ch.row_out !== want.row_out)
                        report_mismatch("row_out", out_ch.row_out, want.row_out);
                    if (out_ch.trades_changed !== want.trades_changed)
                        report_mismatch("trades_changed", 64'(out_ch.trades_changed),
                                        64'(want.trades_changed));
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_gap = $urandom_range(0, 16);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** curveball_matrix_randomizer: FAILED **");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (row_cmds.size() > 0 || in_ch.valid || expected_rows.size() > 0);
        repeat (4) @(posedge clk);
    endtask

    // register write over the config channel, block idle
    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        forever
        begin
            @(negedge clk);
            if (cfg_ch.ready) break;
        end
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == cmr_pkg::REG_ROWS_IN_USE)
            rows_cfg = value[8:0];
        else
            xorshift_q = (value == 0) ? 32'd1 : value;
    endtask

    task automatic queue_item(cmr_pkg::mode_t mode, logic [7:0] row, logic [63:0] bits,
                              logic [23:0] count);
        row_cmd_t cmd;
        cmd.mode  = mode;
        cmd.row   = row;
        cmd.bits  = bits;
        cmd.count = count;
        if (mode == cmr_pkg::MODE_WRITE) written_rows[row] = 1'b1;
        row_cmds.push_back(cmd);
    endtask

    function automatic logic [63:0] random_bitmap();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return r & {$urandom, $urandom} & {$urandom, $urandom};
            3: return r | {$urandom, $urandom};
            default: return r;
        endcase
    endfunction

    // random mix; reads hit written rows only
    task automatic queue_random(int count, bit huge_runs);
        logic [7:0]  row;
        logic [23:0] trades;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    queue_item(cmr_pkg::MODE_WRITE, 8'($urandom_range(0, 255)),
                               random_bitmap(), 24'($urandom));
                3, 4, 5:
                begin
                    do
                        row = 8'($urandom_range(0, 255));
                    while (!written_rows[row]);
                    queue_item(cmr_pkg::MODE_READ, row, {$urandom, $urandom}, 24'($urandom));
                end
                6, 7, 8:
                begin
                    if (huge_runs)
                        trades = 24'($urandom);
                    else if ($urandom_range(0, 9) == 0)
                        trades = 24'($urandom_range(20, 40));
                    else
                        trades = 24'($urandom_range(0, 8));
                    queue_item(cmr_pkg::MODE_TRADE, 8'($urandom), {$urandom, $urandom},
                               trades);
                end
                default:
                    queue_item(cmr_pkg::MODE_NONE, 8'($urandom), {$urandom, $urandom},
                               24'($urandom));
            endcase
        end
    endtask

    // stimulus and end of run
    initial
    begin
        errors = 0;
        quiet = 1'b0;
        rows_cfg = 9'd256;
        xorshift_q = 32'd1;
        foreach (matrix_rows[i]) matrix_rows[i] = '0;
        foreach (written_rows[i]) written_rows[i] = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every mode, skipped and changing trades
        write_reg(cmr_pkg::REG_ROWS_IN_USE, 32'd4);
        write_reg(cmr_pkg::REG_SEED, $urandom);
        queue_item(cmr_pkg::MODE_WRITE, 8'd0, '1, 24'd0);
        queue_item(cmr_pkg::MODE_WRITE, 8'd1, '0, '1);
        queue_item(cmr_pkg::MODE_WRITE, 8'd2, 64'hAAAA_AAAA_AAAA_AAAA, 24'd0);
        queue_item(cmr_pkg::MODE_WRITE, 8'd3, 64'h5555_5555_5555_5555, 24'd0);
        queue_item(cmr_pkg::MODE_WRITE, 8'd255, '1, 24'h80_0001);
        queue_item(cmr_pkg::MODE_READ, 8'd255, '1, '1);
        queue_item(cmr_pkg::MODE_READ, 8'd0, '0, 24'd0);
        queue_item(cmr_pkg::MODE_NONE, 8'd255, '1, '1);
        queue_item(cmr_pkg::MODE_NONE, 8'd0, '0, 24'd0);
        queue_item(cmr_pkg::MODE_TRADE, 8'd0, '0, 24'd0);
        queue_item(cmr_pkg::MODE_TRADE, 8'd255, '1, 24'd3);
        queue_item(cmr_pkg::MODE_WRITE, 8'd1, 64'h8000_0000_0000_0001, 24'd0);
        queue_item(cmr_pkg::MODE_TRADE, 8'd0, '0, 24'd6);
        for (int r = 0; r < 4; r++)
            queue_item(cmr_pkg::MODE_READ, 8'(r), '0, 24'd0);
        queue_random(20, 1'b0);
        wait_drained();

        // too few rows: long runs return at once; zero seed
        write_reg(cmr_pkg::REG_ROWS_IN_USE, 32'd1);
        write_reg(cmr_pkg::REG_SEED, 32'd0);
        queue_item(cmr_pkg::MODE_TRADE, 8'd0, '0, '1);
        queue_random(12, 1'b1);
        wait_drained();
        write_reg(cmr_pkg::REG_ROWS_IN_USE, 32'd0);
        queue_item(cmr_pkg::MODE_TRADE, 8'd0, '0, '1);
        queue_random(10, 1'b1);
        wait_drained();

        // two rows, top seed
        write_reg(cmr_pkg::REG_ROWS_IN_USE, 32'd2);
        write_reg(cmr_pkg::REG_SEED, 32'hFFFF_FFFF);
        queue_random(25, 1'b0);
        wait_drained();

        // wider row set, every trading row written first
        for (int r = 0; r < 16; r++)
            queue_item(cmr_pkg::MODE_WRITE, 8'(r), random_bitmap(), 24'($urandom));
        wait_drained();
        write_reg(cmr_pkg::REG_ROWS_IN_USE, 32'd16);
        write_reg(cmr_pkg::REG_SEED, $urandom);
        queue_random(30, 1'b0);
        wait_drained();

        // no idling to the end
        write_reg(cmr_pkg::REG_SEED, $urandom);
        quiet = 1'b1;
        queue_random(12, 1'b0);
        wait_drained();

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("** curveball_matrix_randomizer: PASSED **");
        else
            $display("** curveball_matrix_randomizer: FAILED **");
        $finish;
    end

endmodule
